// ===== sv/plcm_pkg.sv =====
// Shared types, widths and constants of the powerline canceller with median mode.
package plcm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MEDIAN_MAX_DEF = 64;
  localparam int PH_W           = 24;
  localparam int TURN_W         = 23;
  localparam int SC_W           = 26;
  localparam int COR_W          = 32;
  localparam int MUL_W          = 35;
  localparam int PROD_W         = 70;
  localparam int ACC_W          = 58;
  localparam int PW_W           = 64;
  localparam int OUT_W          = 18;
  localparam int LVL_W          = 16;
  localparam int FAC_W          = 16;
  localparam int BLK_W          = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 23;

  localparam logic [TURN_W-1:0] QUARTER_TURN = 23'h200000;
  localparam logic [17:0]       REFINE_COEF  = 18'd235930;
  localparam logic [15:0]       SKIN_KEEP    = 16'd58982;
  localparam logic [12:0]       SKIN_TAKE    = 13'd6554;

  localparam logic [1:0]        MODE_PASS       = 2'd0;
  localparam logic [1:0]        MODE_CANCEL     = 2'd1;
  localparam logic [1:0]        MODE_MEDIAN     = 2'd2;
  localparam logic [1:0]        MODE_MEDIAN_ALT = 2'd3;

  localparam logic [1:0]        FSEL_RST   = 2'd1;
  localparam logic [FAC_W-1:0]  FACTOR_RST = 16'd65339;
  localparam logic [TURN_W-1:0] STEP_LO_RST = 23'd429744;
  localparam logic [TURN_W-1:0] STEP_HI_RST = 23'd515693;
  localparam logic [BLK_W-1:0]  BLOCK_RST  = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_SELECT = 3'd0,
    CFG_SKIN_ENABLE   = 3'd1,
    CFG_AVG_FACTOR    = 3'd2,
    CFG_STEP_LOW      = 3'd3,
    CFG_STEP_HIGH     = 3'd4,
    CFG_MEDIAN_BLOCK  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_CORR,
    ST_POWER,
    ST_RECON,
    ST_SKIN,
    ST_MED_STORE,
    ST_RANK_LOAD,
    ST_RANK_PIVOT,
    ST_RANK_SCAN,
    ST_MEAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ecg_sample;
    logic signed [SAMPLE_BITS-1:0] skin_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_sample;
    logic signed [LVL_W-1:0] skin_level;
    logic                    band_chosen;
  } out_item_t;

endpackage

// ===== sv/plcm_mult.sv =====
// Shared signed multiplier with registered product.
module plcm_mult (
  input  logic                             clk,
  input  logic signed [plcm_pkg::MUL_W-1:0]  op_a,
  input  logic signed [plcm_pkg::MUL_W-1:0]  op_b,
  output logic signed [plcm_pkg::PROD_W-1:0] prod_r
);
  import plcm_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== sv/plcm_corr_mem.sv =====
// Four-entry correlator memory, reads as zero until an entry is written.
module plcm_corr_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [1:0]                       waddr,
  input  logic signed [plcm_pkg::COR_W-1:0] wdata,
  input  logic [1:0]                       raddr,
  output logic signed [plcm_pkg::COR_W-1:0] rdata_r
);
  import plcm_pkg::*;

  logic signed [COR_W-1:0] mem [4];
  logic [3:0]              vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
  end

endmodule

// ===== sv/plcm_med_mem.sv =====
// Sample store for the block median, one write and one registered read port.
module plcm_med_mem #(
  parameter int DEPTH = plcm_pkg::MEDIAN_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(DEPTH)-1:0]               waddr,
  input  logic signed [plcm_pkg::SAMPLE_BITS-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]               raddr,
  output logic signed [plcm_pkg::SAMPLE_BITS-1:0] rdata_r
);
  import plcm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/powerline_canceller_median.sv =====
// Powerline canceller top level: sequencer, datapath and result register.
// Passthrough: the input sample is the result. Canceller: the 32 products of a sample
//   go one at a time through the shared multiplier.
// Median: each sample is stored in the sample memory; a closing sample adds the rank
//   pass over the sample memory and the mean.
// The result register lets the next sample in while a result waits to be taken.
// Synchronous active-low reset: registers to defaults, phases, averages, fill
//   and correlators to zero; the sample memory is not cleared.
module powerline_canceller_median #(
  parameter int MEDIAN_MAX = plcm_pkg::MEDIAN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  plcm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output plcm_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import plcm_pkg::*;

  localparam int AW = $clog2(MEDIAN_MAX);
  localparam int CW = $clog2(MEDIAN_MAX + 1);
  localparam int BW = (CW > BLK_W) ? CW : BLK_W;

  // saturate to the correlator / average word
  function automatic logic signed [COR_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [COR_W-1:0] y;
    if (&x[PROD_W-1:COR_W-1] || ~|x[PROD_W-1:COR_W-1]) begin
      y = x[COR_W-1:0];
    end else begin
      y = x[PROD_W-1] ? {1'b1, {(COR_W-1){1'b0}}} : {1'b0, {(COR_W-1){1'b1}}};
    end
    return y;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat18(input logic signed [21:0] x);
    logic signed [OUT_W-1:0] y;
    if (&x[21:OUT_W-1] || ~|x[21:OUT_W-1]) begin
      y = x[OUT_W-1:0];
    end else begin
      y = x[21] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    return y;
  endfunction

  // configuration registers
  logic [1:0]        fsel_r, fsel_nxt;
  logic              skin_en_r, skin_en_nxt;
  logic [FAC_W-1:0]  fac_r, fac_nxt;
  logic [TURN_W-1:0] step_lo_r, step_lo_nxt, step_hi_r, step_hi_nxt;
  logic [BLK_W-1:0]  mblk_r, mblk_nxt;

  // sequencer
  state_t            state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [2:0]        sub_r, sub_nxt;

  // held state
  logic [PH_W-1:0]         ph_lo_r, ph_lo_nxt, ph_hi_r, ph_hi_nxt;
  logic signed [COR_W-1:0] avg_r, avg_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;

  // datapath
  logic signed [SAMPLE_BITS-1:0] v_r, v_nxt, v2_r, v2_nxt;
  logic [24:0]                   t_r, t_nxt, d_r, d_nxt;
  logic signed [SC_W-1:0]        sc_r [4];
  logic                          sc_we;
  logic [1:0]                    sc_idx;
  logic signed [SC_W-1:0]        sc_rd;
  logic signed [33:0]            p16_r, p16_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic [PW_W-1:0]               pw0_r, pw0_nxt, pw1_r, pw1_nxt;
  logic                          band_r, band_nxt;
  logic signed [OUT_W-1:0]       result_r, result_nxt;
  logic [CW-1:0]                 i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] xi_r, xi_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_item_r, out_item_nxt;

  // multiplier and memories
  logic signed [MUL_W-1:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          cor_we;
  logic [1:0]                    cor_waddr, cor_raddr;
  logic signed [COR_W-1:0]       cor_wdata, cor_rdata;
  logic                          med_we;
  logic [AW-1:0]                 med_raddr;
  logic signed [SAMPLE_BITS-1:0] med_rdata;

  // parabolic sine of the current angle (k: 0 sin50, 1 cos50, 2 sin60, 3 cos60)
  logic [PH_W-1:0]          ph_sel;
  logic [TURN_W-1:0]        ang_f, ang_a;
  logic                     ang_neg;
  logic signed [PROD_W-1:0] rnd17, rnd23, rnd19, rnd8, cor_sum, rsum, sk_sum;
  logic [28:0]              t_wide;
  logic [24:0]              e_calc, z_calc;
  logic signed [SC_W-1:0]   sc_calc;
  logic [COR_W-1:0]         cor_mag;
  logic signed [21:0]       kq, n_calc, res_calc;
  logic                     rem_nz;
  logic [CW-1:0]            b_eff, b_half, fill_inc, cnt_inc;
  logic [BW-1:0]            mblk_ext;
  logic                     less;
  logic signed [SAMPLE_BITS:0] med_sum, med_mean;
  logic signed [LVL_W-1:0]  lvl;

  assign ph_sel  = k_r[1] ? ph_hi_r : ph_lo_r;
  assign ang_f   = ph_sel[TURN_W-1:0] + (k_r[0] ? QUARTER_TURN : '0);
  assign ang_neg = ang_f[TURN_W-1];
  assign ang_a   = ang_neg ? TURN_W'(24'h800000 - {1'b0, ang_f}) : ang_f;

  assign rnd17   = prod_r + 70'sh20000;
  assign rnd23   = prod_r + 70'sh800000;
  assign rnd19   = prod_r + 70'sh80000;
  assign rnd8    = prod_r + 70'sh80;
  assign t_wide  = {2'b00, ang_a, 4'b0000} - rnd17[46:18];
  assign e_calc  = rnd19[44:20];
  assign z_calc  = t_r - e_calc;
  assign sc_calc = ang_neg ? -$signed({1'b0, z_calc}) : $signed({1'b0, z_calc});

  assign cor_sum = PROD_W'(acc_r) + prod_r + 70'sh8000;
  assign sk_sum  = PROD_W'(acc_r) + (prod_r <<< 16) + 70'sh8000;
  assign cor_mag = cor_rdata[COR_W-1] ? COR_W'(-(33'(cor_rdata))) : COR_W'(cor_rdata);

  // reconstruction: twice the sum, floored by 2^40, truncated toward zero after the subtract
  assign rsum     = PROD_W'(acc_r) + prod_r;
  assign kq       = rsum[60:39];
  assign rem_nz   = |rsum[38:0];
  assign n_calc   = 22'(v_r) - kq;
  assign res_calc = (rem_nz && n_calc > 0) ? n_calc - 22'sd1 : n_calc;

  // effective block length: clamped, then even
  assign mblk_ext = BW'(mblk_r);
  always_comb begin
    if (mblk_ext < BW'(2)) begin
      b_eff = CW'(2);
    end else if (mblk_ext > BW'(MEDIAN_MAX)) begin
      b_eff = CW'(MEDIAN_MAX);
    end else begin
      b_eff = CW'(mblk_ext);
    end
    b_eff[0] = 1'b0;
  end
  assign b_half   = b_eff >> 1;
  assign fill_inc = fill_r + CW'(1);

  // stable rank: smaller value, or equal value at a lower index
  assign less    = (med_rdata < xi_r) || ((med_rdata == xi_r) && ((j_r - CW'(1)) < i_r));
  assign cnt_inc = cnt_r + CW'(less);

  // mean of the middle pair, truncated toward zero
  assign med_sum  = (SAMPLE_BITS+1)'(lo_r) + (SAMPLE_BITS+1)'(hi_r);
  assign med_mean = (med_sum + $signed((SAMPLE_BITS+1)'(med_sum[SAMPLE_BITS]))) >>> 1;

  assign lvl = avg_r[COR_W-1:16] + LVL_W'(avg_r[COR_W-1] && (|avg_r[15:0]));

  assign sc_rd     = sc_r[sc_idx];
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    fsel_nxt    = fsel_r;
    skin_en_nxt = skin_en_r;
    fac_nxt     = fac_r;
    step_lo_nxt = step_lo_r;
    step_hi_nxt = step_hi_r;
    mblk_nxt    = mblk_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_SELECT: fsel_nxt    = cfg_data[1:0];
        CFG_SKIN_ENABLE:   skin_en_nxt = cfg_data[0];
        CFG_AVG_FACTOR:    fac_nxt     = cfg_data[FAC_W-1:0];
        CFG_STEP_LOW:      step_lo_nxt = cfg_data[TURN_W-1:0];
        CFG_STEP_HIGH:     step_hi_nxt = cfg_data[TURN_W-1:0];
        CFG_MEDIAN_BLOCK:  mblk_nxt    = cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    sub_nxt    = sub_r;
    ph_lo_nxt  = ph_lo_r;
    ph_hi_nxt  = ph_hi_r;
    avg_nxt    = avg_r;
    fill_nxt   = fill_r;
    v_nxt      = v_r;
    v2_nxt     = v2_r;
    t_nxt      = t_r;
    d_nxt      = d_r;
    p16_nxt    = p16_r;
    acc_nxt    = acc_r;
    pw0_nxt    = pw0_r;
    pw1_nxt    = pw1_r;
    band_nxt   = band_r;
    result_nxt = result_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    xi_nxt     = xi_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    sc_we      = 1'b0;
    sc_idx     = k_r;
    mul_a      = '0;
    mul_b      = '0;
    cor_we     = 1'b0;
    cor_waddr  = k_r;
    cor_wdata  = sat32(cor_sum >>> 16);
    cor_raddr  = k_r;
    med_we     = 1'b0;
    med_raddr  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt  = in_item.ecg_sample;
          v2_nxt = in_item.skin_sample;
          case (fsel_r) inside
            MODE_PASS: begin
              result_nxt = OUT_W'(in_item.ecg_sample);
              band_nxt   = 1'b0;
              state_nxt  = ST_OUT;
            end
            MODE_CANCEL: begin
              k_nxt     = 2'd0;
              sub_nxt   = 3'd0;
              state_nxt = ST_ANGLE;
            end
            MODE_MEDIAN, MODE_MEDIAN_ALT: state_nxt = ST_MED_STORE;
          endcase
        end
      end

      ST_ANGLE: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: begin
            mul_a = MUL_W'(ang_a);
            mul_b = MUL_W'(ang_a);
          end
          3'd1: t_nxt = t_wide[24:0];
          3'd2: begin
            mul_a = MUL_W'(t_r);
            mul_b = MUL_W'(t_r);
          end
          3'd3: d_nxt = t_r - rnd23[48:24];
          3'd4: begin
            mul_a = MUL_W'(d_r);
            mul_b = MUL_W'(REFINE_COEF);
          end
          default: begin
            sc_we   = 1'b1;
            sub_nxt = 3'd0;
            k_nxt   = k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_nxt = ST_CORR;
            end
          end
        endcase
      end

      ST_CORR: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: begin
            mul_a = MUL_W'(v_r);
            mul_b = MUL_W'(sc_rd);
          end
          3'd1: begin
            p16_nxt = rnd8[41:8];
            mul_a   = MUL_W'(cor_rdata);
            mul_b   = MUL_W'(fac_r);
          end
          3'd2: begin
            acc_nxt = ACC_W'(prod_r);
            mul_a   = MUL_W'(p16_r);
            mul_b   = MUL_W'(17'h10000 - {1'b0, fac_r});
          end
          default: begin
            cor_we  = 1'b1;
            sub_nxt = 3'd0;
            k_nxt   = k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_nxt = ST_POWER;
            end
          end
        endcase
      end

      ST_POWER: begin
        cor_raddr = sub_r[1:0];
        sub_nxt   = sub_r + 3'd1;
        if (sub_r == 3'd0) begin
          pw0_nxt = '0;
          pw1_nxt = '0;
        end
        if (sub_r >= 3'd1 && sub_r <= 3'd4) begin
          mul_a = MUL_W'(cor_mag);
          mul_b = MUL_W'(cor_mag);
        end
        if (sub_r == 3'd2 || sub_r == 3'd3) begin
          pw0_nxt = pw0_r + prod_r[PW_W-1:0];
        end
        if (sub_r == 3'd4 || sub_r == 3'd5) begin
          pw1_nxt = pw1_r + prod_r[PW_W-1:0];
        end
        if (sub_r == 3'd5) begin
          sub_nxt   = 3'd0;
          state_nxt = ST_RECON;
        end
      end

      ST_RECON: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: begin
            // equal powers go to the 60 Hz band
            band_nxt  = !(pw0_r > pw1_r);
            cor_raddr = {band_nxt, 1'b0};
          end
          3'd1: begin
            cor_raddr = {band_r, 1'b1};
            sc_idx    = {band_r, 1'b0};
            mul_a     = MUL_W'(cor_rdata);
            mul_b     = MUL_W'(sc_rd);
          end
          3'd2: begin
            acc_nxt = ACC_W'(prod_r);
            sc_idx  = {band_r, 1'b1};
            mul_a   = MUL_W'(cor_rdata);
            mul_b   = MUL_W'(sc_rd);
          end
          default: begin
            result_nxt = sat18(res_calc);
            sub_nxt    = 3'd0;
            state_nxt  = ST_SKIN;
          end
        endcase
      end

      ST_SKIN: begin
        sub_nxt = sub_r + 3'd1;
        if (sub_r == 3'd0) begin
          mul_a = MUL_W'(avg_r);
          mul_b = MUL_W'(SKIN_KEEP);
        end else if (sub_r == 3'd1) begin
          acc_nxt = ACC_W'(prod_r);
          mul_a   = MUL_W'(v2_r);
          mul_b   = MUL_W'(SKIN_TAKE);
        end else begin
          avg_nxt = sat32(sk_sum >>> 16);
        end
        if (!skin_en_r || sub_r == 3'd2) begin
          ph_lo_nxt = ph_lo_r + PH_W'(step_lo_r);
          ph_hi_nxt = ph_hi_r + PH_W'(step_hi_r);
          sub_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end
      end

      ST_MED_STORE: begin
        med_we = (fill_r < CW'(MEDIAN_MAX));
        if (fill_inc < b_eff) begin
          fill_nxt  = fill_inc;
          state_nxt = ST_IDLE;
        end else begin
          fill_nxt  = '0;
          i_nxt     = '0;
          state_nxt = ST_RANK_LOAD;
        end
      end

      ST_RANK_LOAD: begin
        med_raddr = i_r[AW-1:0];
        state_nxt = ST_RANK_PIVOT;
      end

      ST_RANK_PIVOT: begin
        xi_nxt    = med_rdata;
        med_raddr = '0;
        j_nxt     = CW'(1);
        cnt_nxt   = '0;
        state_nxt = ST_RANK_SCAN;
      end

      ST_RANK_SCAN: begin
        med_raddr = j_r[AW-1:0];
        cnt_nxt   = cnt_inc;
        j_nxt     = j_r + CW'(1);
        if (j_r == b_eff) begin
          if (cnt_inc == b_half - CW'(1)) begin
            lo_nxt = xi_r;
          end
          if (cnt_inc == b_half) begin
            hi_nxt = xi_r;
          end
          i_nxt     = i_r + CW'(1);
          state_nxt = (i_r + CW'(1) == b_eff) ? ST_MEAN : ST_RANK_LOAD;
        end
      end

      ST_MEAN: begin
        result_nxt = OUT_W'(med_mean);
        band_nxt   = 1'b0;
        state_nxt  = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.filtered_sample = result_r;
          out_item_nxt.skin_level      = lvl;
          out_item_nxt.band_chosen     = band_r;
          state_nxt                    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r      <= FSEL_RST;
      skin_en_r   <= 1'b1;
      fac_r       <= FACTOR_RST;
      step_lo_r   <= STEP_LO_RST;
      step_hi_r   <= STEP_HI_RST;
      mblk_r      <= BLOCK_RST;
      k_r         <= '0;
      sub_r       <= '0;
      ph_lo_r     <= '0;
      ph_hi_r     <= '0;
      avg_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsel_r      <= fsel_nxt;
      skin_en_r   <= skin_en_nxt;
      fac_r       <= fac_nxt;
      step_lo_r   <= step_lo_nxt;
      step_hi_r   <= step_hi_nxt;
      mblk_r      <= mblk_nxt;
      k_r         <= k_nxt;
      sub_r       <= sub_nxt;
      ph_lo_r     <= ph_lo_nxt;
      ph_hi_r     <= ph_hi_nxt;
      avg_r       <= avg_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    v2_r       <= v2_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    p16_r      <= p16_nxt;
    acc_r      <= acc_nxt;
    pw0_r      <= pw0_nxt;
    pw1_r      <= pw1_nxt;
    band_r     <= band_nxt;
    result_r   <= result_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    xi_r       <= xi_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_item_r <= out_item_nxt;
    if (sc_we) begin
      sc_r[k_r] <= sc_calc;
    end
  end

  plcm_mult u_mult (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  plcm_corr_mem u_corr_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (cor_we),
    .waddr   (cor_waddr),
    .wdata   (cor_wdata),
    .raddr   (cor_raddr),
    .rdata_r (cor_rdata)
  );

  plcm_med_mem #(
    .DEPTH (MEDIAN_MAX)
  ) u_med_mem (
    .clk     (clk),
    .we      (med_we),
    .waddr   (fill_r[AW-1:0]),
    .wdata   (v_r),
    .raddr   (med_raddr),
    .rdata_r (med_rdata)
  );

  // a canceller sample always starts with the angle sequence
  a_cancel_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && fsel_r == MODE_CANCEL) |=> state_r == ST_ANGLE)
    else $error("canceller sample did not start the angle sequence");

  // correlators are written back only at the last step of their update
  a_corr_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cor_we |-> (state_r == ST_CORR && sub_r == 3'd3))
    else $error("correlator write outside its update step");

  // the fill count never passes the store depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MEDIAN_MAX))
    else $error("median fill beyond store depth");

  // a waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("pending result lost");

endmodule
